### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hex ASCII packet deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication: the consequent is checked after the antecedent.
`define ASSERT_DLY2(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### hdl/hapd_pkg.sv
// ----------------------------------------------------------------------------
// hapd_pkg
// Types, codes and helpers shared by the hex ASCII packet deframer.
// ----------------------------------------------------------------------------
package hapd_pkg;

  localparam int MAX_CHARS = 60;
  localparam int MIN_CHARS = 6;
  localparam int DEPTH     = MAX_CHARS / 2;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int NB_W      = $clog2(DEPTH + 1);

  localparam int TIME_W    = 16;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] HEX_DIGIT_BASE = 8'd48;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd55;

  localparam logic REG_TIMEOUT_IDX = 1'b0;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_CHAR = 3'd3,
    ST_BAD_LEN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_FOOTER = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RD_IDLE  = 2'd0,
    RD_ISSUE = 2'd1,
    RD_LOAD  = 2'd2
  } rd_state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } fail_req_t;

  typedef struct packed {
    logic            valid;
    logic [NB_W-1:0] count;
  } emit_req_t;

  typedef struct packed {
    logic busy;
    logic free;
  } rd_stat_t;

  // Bit 4 flags a valid upper-case hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - HEX_DIGIT_BASE;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - HEX_ALPHA_BASE;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

### hdl/hapd_ram.sv
// ----------------------------------------------------------------------------
// hapd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module hapd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/hapd_rx.sv
// ----------------------------------------------------------------------------
// hapd_rx
// Receive control: header hunt, nibble packing into the byte store, length
// and timeout checks, and requests for failure items and packet readout.
// ----------------------------------------------------------------------------
module hapd_rx import hapd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          cmd,
  input  logic [7:0]          rx_char,
  input  logic [TIME_W-1:0]   timeout_ticks,
  output logic                ram_we,
  output logic [ADDR_W-1:0]   ram_waddr,
  output logic [7:0]          ram_wdata,
  output fail_req_t           fail_req,
  output emit_req_t           emit_req
);

  phase_t            phase, phase_next;
  logic              first_plus_seen, first_plus_seen_next;
  logic [CNT_W-1:0]  char_count, char_count_next;
  logic [TIME_W-1:0] elapsed, elapsed_next;
  logic [3:0]        hi_nib;

  logic [7:0]        c;
  logic [4:0]        hex;
  logic              active, ev_start, ev_tick, ev_char, chr;
  logic [TIME_W-1:0] el_inc;
  logic [CNT_W-1:0]  cnt_inc;
  logic              tick_fail, char_tmo, hdr_plus, hdr_other, data_hex;
  logic              too_long, data_minus, bad_len, bad_char, foot_minus, fail_any;

  assign c        = rx_char;
  assign hex      = hex_decode(c);
  assign active   = (phase != PH_IDLE);
  assign ev_start = accept && (cmd == CMD_START);
  assign ev_tick  = accept && (cmd == CMD_TICK) && active;
  assign ev_char  = accept && (cmd == CMD_CHAR) && active;
  assign el_inc   = (elapsed == '1) ? elapsed : elapsed + TIME_W'(1);
  assign cnt_inc  = char_count + CNT_W'(1);

  assign tick_fail  = ev_tick && (el_inc >= timeout_ticks);
  assign char_tmo   = ev_char && (elapsed >= timeout_ticks);
  assign chr        = ev_char && !char_tmo;
  assign hdr_plus   = chr && (phase == PH_HEADER) && (c == CHAR_PLUS);
  assign hdr_other  = chr && (phase == PH_HEADER) && (c != CHAR_PLUS);
  assign data_hex   = chr && (phase == PH_DATA) && hex[4];
  assign too_long   = data_hex && (cnt_inc >= CNT_W'(MAX_CHARS));
  assign data_minus = chr && (phase == PH_DATA) && !hex[4] && (c == CHAR_MINUS);
  assign bad_len    = data_minus &&
                      ((char_count < CNT_W'(MIN_CHARS)) || char_count[0]);
  assign bad_char   = chr && (phase == PH_DATA) && !hex[4] && (c != CHAR_MINUS);
  assign foot_minus = chr && (phase == PH_FOOTER) && (c == CHAR_MINUS);
  assign fail_any   = tick_fail || char_tmo || too_long || bad_len || bad_char;

  always_comb begin
    phase_next = phase;
    if (ev_start) begin
      phase_next = PH_HEADER;
    end else if (fail_any) begin
      phase_next = PH_IDLE;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (hdr_plus && first_plus_seen) begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_minus) begin
            phase_next = PH_FOOTER;
          end
        end
        PH_FOOTER: begin
          if (foot_minus) begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    first_plus_seen_next = first_plus_seen;
    char_count_next      = char_count;
    elapsed_next         = elapsed;
    if (ev_start) begin
      first_plus_seen_next = 1'b0;
      char_count_next      = '0;
      elapsed_next         = '0;
    end else begin
      if (ev_tick) begin
        elapsed_next = el_inc;
      end
      if (hdr_plus) begin
        first_plus_seen_next = 1'b1;
        if (first_plus_seen) begin
          char_count_next = '0;
        end
      end
      if (hdr_other || fail_any || foot_minus) begin
        first_plus_seen_next = 1'b0;
      end
      if (data_hex) begin
        char_count_next = cnt_inc;
      end
    end
  end

  always_comb begin
    ram_we          = data_hex && char_count[0];
    ram_waddr       = ADDR_W'(char_count >> 1);
    ram_wdata       = {hi_nib, hex[3:0]};
    emit_req.valid  = foot_minus;
    emit_req.count  = NB_W'(char_count >> 1);
    fail_req.valid  = fail_any;
    fail_req.status = ST_DATA;
    if (tick_fail || char_tmo) begin
      fail_req.status = ST_TIMEOUT;
    end else if (too_long) begin
      fail_req.status = ST_TOO_LONG;
    end else if (bad_len) begin
      fail_req.status = ST_BAD_LEN;
    end else if (bad_char) begin
      fail_req.status = ST_BAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      first_plus_seen <= 1'b0;
      char_count      <= '0;
      elapsed         <= '0;
    end else begin
      phase           <= phase_next;
      first_plus_seen <= first_plus_seen_next;
      char_count      <= char_count_next;
      elapsed         <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (data_hex && !char_count[0]) begin
      hi_nib <= hex[3:0];
    end
  end

endmodule

### hdl/hapd_rdout.sv
// ----------------------------------------------------------------------------
// hapd_rdout
// Readout sequencer and output register: walks the byte store for a finished
// packet and merges single failure items into the result stream.
// ----------------------------------------------------------------------------
module hapd_rdout import hapd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  fail_req_t         fail_req,
  input  emit_req_t         emit_req,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output status_t           out_status,
  output logic              out_last,
  output rd_stat_t          rd_stat
);

  rd_state_t       state, state_next;
  logic [NB_W-1:0] idx, idx_next;
  logic [NB_W-1:0] n_bytes;
  logic [NB_W-1:0] idx_inc;
  logic            free, load, is_last;

  assign free    = !out_valid || out_ready;
  assign idx_inc = idx + NB_W'(1);
  assign is_last = (idx_inc == n_bytes);

  always_comb begin
    state_next = state;
    case (state)
      RD_IDLE: begin
        if (emit_req.valid) begin
          state_next = RD_ISSUE;
        end
      end
      RD_ISSUE: begin
        if (free) begin
          state_next = RD_LOAD;
        end
      end
      RD_LOAD: begin
        state_next = is_last ? RD_IDLE : RD_ISSUE;
      end
      default: state_next = RD_IDLE;
    endcase
  end

  always_comb begin
    ram_re       = (state == RD_ISSUE) && free;
    ram_raddr    = ADDR_W'(idx);
    load         = (state == RD_LOAD);
    rd_stat.busy = (state != RD_IDLE);
    rd_stat.free = free;
    idx_next     = idx;
    if (state == RD_IDLE) begin
      idx_next = '0;
    end else if (load) begin
      idx_next = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RD_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load || fail_req.valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req.valid) begin
      n_bytes <= emit_req.count;
    end
    if (load) begin
      out_byte   <= ram_rdata;
      out_status <= ST_DATA;
      out_last   <= is_last;
    end else if (fail_req.valid) begin
      out_byte   <= 8'd0;
      out_status <= fail_req.status;
      out_last   <= 1'b1;
    end
  end

endmodule

### hdl/hex_ascii_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// hex_ascii_packet_deframer_top
// Deframes "++" headed, "--" trailed hex ASCII packets into bytes.
// ----------------------------------------------------------------------------
// Start, tick and character items are accepted while no readout runs and
// the output register is empty or being emptied. The closing '-' of a
// packet starts a readout of n = 3 to 29 bytes from the byte store through
// its single registered read port, one byte at a time, each read issued
// once the previous byte is loaded and the output register is free. Failures
// leave as a single status item with last set. The store is never cleared;
// every entry read is written during the same packet.
`include "assert_macros.svh"

module hex_ascii_packet_deframer_top import hapd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: rx_char [7:0]
  // s_tuser: command [1:0]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic [1:0]            s_tuser,
  // m_tdata: packet byte [7:0]
  // m_tuser: status [2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  output logic [2:0]            m_tuser,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [TIME_W-1:0] timeout_ticks;
  logic              reg_hit;
  logic              accept;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  fail_req_t         fail_req;
  emit_req_t         emit_req;
  rd_stat_t          rd_stat;
  logic [7:0]        out_byte;
  status_t           out_status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_TIMEOUT_IDX);
  assign prdata  = reg_hit ? APB_DATA_W'(timeout_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      timeout_ticks <= pwdata[TIME_W-1:0];
    end
  end

  assign s_tready = !rd_stat.busy && rd_stat.free;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_status;

  hapd_rx u_rx (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (s_tuser),
    .rx_char       (s_tdata),
    .timeout_ticks (timeout_ticks),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .fail_req      (fail_req),
    .emit_req      (emit_req)
  );

  hapd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hapd_rdout u_rdout (
    .clk        (clk),
    .rst        (rst),
    .fail_req   (fail_req),
    .emit_req   (emit_req),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (m_tlast),
    .rd_stat    (rd_stat)
  );

  `ASSERT_IMPL(a_no_rw_overlap, clk, rst, ram_we, !ram_re, "store written during readout")
  `ASSERT_DLY2(a_read_lands, clk, rst, ram_re, m_tvalid && (m_tuser == ST_DATA), "read lost")
  `ASSERT_IMPL(a_fail_form, clk, rst, m_tvalid && (m_tuser != ST_DATA), (m_tdata == '0) && m_tlast, "bad fail item")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, character and tick items into the hex ASCII packet deframer,
// first from a short table of directed cases and then as random frames under
// several timeout settings, and checks every output item against a local
// model of the deframer.
// ----------------------------------------------------------------------------
module testbench import hapd_pkg::*; ();

  typedef struct {
    logic [7:0] pkt_byte;
    status_t    status;
    logic       last;
  } rx_byte_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {FR_GOOD, FR_BAD_LEN, FR_BAD_CHAR, FR_TOO_LONG, FR_NOISE} frame_kind_t;

  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [15:0] arg;
    logic        typed;
    status_t     st;
  } dir_row_t;

  localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT_IDX, 2'b00};
  localparam int DIR_ROWS = 36;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [15:0] timeout_cfg = TIMEOUT_RESET;
  phase_t      rx_phase = PH_IDLE;
  logic        plus_seen = 1'b0;
  logic [3:0]  nibbles [MAX_CHARS];
  int          char_cnt = 0;
  logic [15:0] ticks = '0;

  rx_byte_t expected_bytes [$];
  rx_byte_t step_out [$];
  int       live_items = 0;
  int       mismatches = 0;
  bit       calm = 1'b0;
  int       ready_hold = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_ITEM, CMD_CHAR,  16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_TICK,  16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_NONE,  16'hFF,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_START, 16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'hFF,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_START, 16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h61,          1'b1, ST_BAD_CHAR},
    '{ROW_ITEM, CMD_START, 16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h46,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h30,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_MINUS), 1'b1, ST_BAD_LEN},
    '{ROW_ITEM, CMD_START, 16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_PLUS),  1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h30,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h31,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h41,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h42,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h46,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h39,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_MINUS), 1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h78,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'(CHAR_MINUS), 1'b0, ST_DATA},
    '{ROW_CFG,  CMD_NONE,  16'd0,           1'b0, ST_DATA},
    '{ROW_ITEM, CMD_START, 16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_CHAR,  16'h41,          1'b1, ST_TIMEOUT},
    '{ROW_CFG,  CMD_NONE,  16'd2,           1'b0, ST_DATA},
    '{ROW_ITEM, CMD_START, 16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_TICK,  16'h00,          1'b0, ST_DATA},
    '{ROW_ITEM, CMD_TICK,  16'h00,          1'b1, ST_TIMEOUT}
  };

  hex_ascii_packet_deframer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
    return -1;
  endfunction

  function automatic void fail_rx(status_t code);
    step_out.push_back('{8'd0, code, 1'b1});
    rx_phase  = PH_IDLE;
    plus_seen = 1'b0;
  endfunction

  function automatic void deframe_step(cmd_t cmd, logic [7:0] ch);
    int nib;
    int n;
    step_out.delete();
    if (cmd == CMD_START) begin
      rx_phase  = PH_HEADER;
      plus_seen = 1'b0;
      char_cnt  = 0;
      ticks     = '0;
      return;
    end
    if (rx_phase == PH_IDLE || cmd == CMD_NONE) return;
    if (cmd == CMD_TICK) begin
      if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
      if (ticks >= timeout_cfg) fail_rx(ST_TIMEOUT);
      return;
    end
    if (ticks >= timeout_cfg) begin
      fail_rx(ST_TIMEOUT);
      return;
    end
    case (rx_phase)
      PH_HEADER: begin
        if (ch == CHAR_PLUS) begin
          if (plus_seen) begin
            rx_phase = PH_DATA;
            char_cnt = 0;
          end
          plus_seen = 1'b1;
        end else begin
          plus_seen = 1'b0;
        end
      end
      PH_DATA: begin
        nib = nibble_of(ch);
        if (nib >= 0) begin
          if (char_cnt < MAX_CHARS) nibbles[char_cnt] = nib[3:0];
          char_cnt++;
          if (char_cnt >= MAX_CHARS) fail_rx(ST_TOO_LONG);
        end else if (ch == CHAR_MINUS) begin
          if (char_cnt < MIN_CHARS || char_cnt[0]) fail_rx(ST_BAD_LEN);
          else rx_phase = PH_FOOTER;
        end else begin
          fail_rx(ST_BAD_CHAR);
        end
      end
      default: begin
        if (ch == CHAR_MINUS) begin
          n = char_cnt / 2;
          for (int i = 0; i < n; i++)
            step_out.push_back('{{nibbles[2*i], nibbles[2*i+1]}, ST_DATA, i == n - 1});
          rx_phase  = PH_IDLE;
          plus_seen = 1'b0;
        end
      end
    endcase
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [7:0] ch,
                           input logic typed = 1'b0, input status_t st = ST_DATA);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_START || (cmd != CMD_NONE && rx_phase != PH_IDLE)) live_items++;
    deframe_step(cmd, ch);
    if (typed) begin
      expected_bytes.push_back('{8'd0, st, 1'b1});
    end else begin
      foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    timeout_cfg = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'd0, value}) begin
      $error("timeout_ticks: expected %0d, got %0d", value, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    int         n;
    logic [7:0] c;
    int         v;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 8))
        send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      return;
    end
    send_item(CMD_START, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) begin
      send_item(CMD_CHAR, CHAR_PLUS);
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_PLUS);
      send_item(CMD_CHAR, c);
    end
    send_item(CMD_CHAR, CHAR_PLUS);
    send_item(CMD_CHAR, CHAR_PLUS);
    case (kind)
      FR_GOOD:     n = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(9, 29)
                                                   : 2 * $urandom_range(3, 8);
      FR_BAD_LEN:  n = ($urandom_range(0, 1) == 0) ? 2 * $urandom_range(0, 2)
                                                   : 2 * $urandom_range(0, 28) + 1;
      FR_TOO_LONG: n = MAX_CHARS;
      default:     n = $urandom_range(0, 20);
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3)) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
      v = $urandom_range(0, 15);
      send_item(CMD_CHAR, 8'(v + (v < 10 ? 48 : 55)));
    end
    if (kind == FR_BAD_CHAR) begin
      if ($urandom_range(0, 2) == 0) c = 8'(8'h61 + $urandom_range(0, 5));
      else do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0 || c == CHAR_MINUS);
      send_item(CMD_CHAR, c);
    end else if (kind != FR_TOO_LONG) begin
      send_item(CMD_CHAR, CHAR_MINUS);
      if (kind == FR_GOOD) begin
        repeat ($urandom_range(0, 2)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_MINUS);
          send_item(CMD_CHAR, c);
        end
        send_item(CMD_CHAR, CHAR_MINUS);
      end
    end
  endtask

  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 15);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rx_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output item: pkt_byte %0h, status %0d, last %0b",
               m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.pkt_byte) begin
          $error("pkt_byte: expected %0h, got %0h", want.pkt_byte, m_tdata);
          mismatches++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [15:0] phase_timeout [6];
    int          budget [6];
    int          goal;
    int          r;
    frame_kind_t kind;
    phase_timeout = '{16'd1000, 16'd65535, 16'd0, 16'd20, 16'd0, 16'd1000};
    budget        = '{45, 40, 8, 35, 35, 45};
    phase_timeout[4] = 16'($urandom_range(30, 400));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain_results();
        set_timeout(dir_table[i].arg);
      end else begin
        send_item(dir_table[i].cmd, dir_table[i].arg[7:0], dir_table[i].typed,
                  dir_table[i].st);
      end
    end
    for (int p = 0; p < 6; p++) begin
      drain_results();
      if (p == 5) calm = 1'b1;
      set_timeout(phase_timeout[p]);
      goal = live_items + budget[p];
      while (live_items < goal) begin
        r = $urandom_range(0, 99);
        if (r < 55) kind = FR_GOOD;
        else if (r < 67) kind = FR_BAD_LEN;
        else if (r < 79) kind = FR_BAD_CHAR;
        else if (r < 83) kind = FR_TOO_LONG;
        else kind = FR_NOISE;
        send_frame(kind);
      end
    end
    drain_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
